[sv/mwd_pkg.sv]
// Shared types, constants and the tanh lookup table of the multimode waveshaper.
// Stands alone; used by multimode_waveshaper_distortion and mwd_checker.
package mwd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int TQ        = 30;
    localparam int IFRAC     = 24;
    localparam int TANH_PTS  = 256;
    localparam int TANH_LOG2 = $clog2(TANH_PTS);
    localparam int TW        = TQ + 1;
    localparam int FRAC_W    = IFRAC + 2;

    localparam logic       REG_MODE  = 1'b0;
    localparam logic       REG_DRIVE = 1'b1;

    typedef enum logic [1:0] {
        MODE_TUBE = 2'd0,
        MODE_JFET = 2'd1,
        MODE_FUZZ = 2'd2
    } mode_t;

    localparam logic [1:0]  MODE_RST  = 2'd0;
    localparam logic [15:0] DRIVE_RST = 16'd32768;

    localparam int G_RST = 65536 + 19 * 32768;
    localparam int B_RST = (G_RST / 5 > 65536) ? 65536 : G_RST / 5;
    localparam int C_RST = 65536 - int'((longint'(B_RST) * 39322 + 32768) >> 16);

    localparam logic signed [31:0] FUZZ_POS = 32'sd11744051;
    localparam logic signed [31:0] FUZZ_NEG = 32'sd10066330;
    localparam logic [20:0]        KNEE_K   = 21'd1677722;
    localparam logic [13:0]        TUBE_K   = 14'd9830;
    localparam logic [15:0]        CLEAN_K  = 16'd39322;
    localparam logic [15:0]        NEG_K    = 16'd52429;
    localparam logic [19:0]        DIV5_K   = 20'd838861;

    typedef struct packed {
        logic pos;
        logic fhi;
        logic flo;
    } xflags_t;

    typedef logic [TANH_PTS:0][TW-1:0] tanh_rom_t;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/N) in Q.30 via the addition formula, built at elaboration
    function automatic tanh_rom_t build_tanh_rom();
        logic [63:0] d;
        logic [63:0] d2;
        logic [63:0] d3;
        logic [63:0] d5;
        logic [63:0] d7;
        logic [63:0] h;
        logic [63:0] t;
        logic [63:0] den;
        tanh_rom_t   rom;
        d   = ((64'd4 << TQ) + 64'(TANH_PTS / 2)) / 64'(TANH_PTS);
        d2  = (d * d) >> TQ;
        d3  = (d2 * d) >> TQ;
        d5  = (d3 * d2) >> TQ;
        d7  = (d5 * d2) >> TQ;
        h   = d - d3 / 64'd3 + (64'd2 * d5) / 64'd15 - (64'd17 * d7) / 64'd315;
        t   = '0;
        rom = '0;
        for (int k = 1; k <= TANH_PTS; k++)
        begin
            den    = (64'd1 << TQ) + ((t * h) >> TQ);
            t      = udiv64(((t + h) << TQ) + (den >> 1), den);
            rom[k] = t[TW-1:0];
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

[sv/multimode_waveshaper_distortion.sv]
// Multimode waveshaper: tube, JFET and fuzz transfer curves on a Q2.21 sample stream.
// Depends on mwd_pkg for constants and the tanh table.

// Takes one sample per clock unless a waiting output item is stalled, and
// shapes it in an eleven-stage pipeline (gain multiply, squaring, tanh table
// read and interpolation multiply, mixing multiplies, rounding and clamp).
// Holding m_tready low while an item waits at the output freezes the whole
// pipeline, so s_tready follows m_tready in that case. The gain and JFET
// blend terms derived from the drive register pass through g, b and c in turn.
module multimode_waveshaper_distortion
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample_out
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  mode_reg;
    logic [15:0] drive_reg;
    logic [20:0] g_reg;
    logic [16:0] b_reg;
    logic [16:0] c_reg;
    logic [20:0] g_next;
    logic [16:0] b_next;
    logic [16:0] c_next;
    logic [40:0] bq;
    logic [32:0] bm;
    logic        cfg_wr;

    logic        en;
    logic [10:0] valid_reg;
    logic [10:0] last_reg;
    logic        jfet;
    logic        fuzz;

    logic [23:0]             sample_pipe_reg [0:8];
    logic signed [31:0]      x_pipe_reg      [1:8];
    mwd_pkg::xflags_t        flag_pipe_reg   [2:8];

    logic [61:0]        xx_reg;
    logic signed [34:0] arg2_reg;
    logic signed [34:0] arg3_reg;
    logic [51:0]        sqm_reg;
    logic signed [37:0] u_reg;
    logic               neg5_reg;
    logic               sat5_reg;
    logic [30:0]        base5_reg;
    logic [24:0]        diff5_reg;
    logic [25:0]        frac5_reg;
    logic [50:0]        prod_reg;
    logic [30:0]        base6_reg;
    logic               neg6_reg;
    logic               sat6_reg;
    logic [24:0]        thm7_reg;
    logic               neg7_reg;
    logic [45:0]        m_reg;
    logic [24:0]        thm8_reg;
    logic               neg8_reg;
    logic signed [44:0] cs_reg;
    logic signed [43:0] bd_reg;
    logic signed [31:0] ys_reg;
    logic [23:0]        out_reg;

    logic signed [31:0] x_next;
    logic [61:0]        xx_next;
    logic signed [34:0] arg_next;
    mwd_pkg::xflags_t   flag_next;
    logic [51:0]        sqm_next;
    logic signed [37:0] u_next;
    logic               neg5_next;
    logic               sat5_next;
    logic [30:0]        base5_next;
    logic [24:0]        diff5_next;
    logic [25:0]        frac5_next;
    logic [50:0]        prod_next;
    logic [24:0]        thm7_next;
    logic [45:0]        m_next;
    logic signed [44:0] cs_next;
    logic signed [43:0] bd_next;
    logic signed [31:0] ys_next;
    logic [23:0]        out_next;

    logic signed [26:0] s_in;
    logic signed [48:0] gs_prod;
    logic signed [63:0] xsq;
    logic signed [34:0] x35;
    logic signed [34:0] ex_sel;
    logic [37:0]        sq;
    logic [35:0]        sqm_rnd;
    logic [37:0]        umag;
    logic [8:0]         idx;
    logic [8:0]         idx_nx;
    logic [31:0]        tsum;
    logic [20:0]        mconst;
    logic [21:0]        knee;
    logic [25:0]        dmag;
    logic signed [25:0] d_val;
    logic signed [25:0] th_val;
    logic signed [26:0] s_mix;
    logic signed [45:0] jsum;
    logic signed [31:0] y_val;
    logic signed [32:0] y_rnd;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[2])
            mwd_pkg::REG_MODE:  prdata = {30'd0, mode_reg};
            mwd_pkg::REG_DRIVE: prdata = {16'd0, drive_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        g_next = 21'(32'd65536 + 32'(drive_reg) * 32'd19);
        bq     = 41'(g_reg) * 41'(mwd_pkg::DIV5_K);
        b_next = (bq[40:22] >= 19'd65536) ? 17'd65536 : 17'(bq[40:22]);
        bm     = 33'(b_reg) * 33'(mwd_pkg::CLEAN_K);
        c_next = 17'd65536 - 17'((bm + 33'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mwd_pkg::MODE_RST;
            drive_reg <= mwd_pkg::DRIVE_RST;
            g_reg     <= 21'(mwd_pkg::G_RST);
            b_reg     <= 17'(mwd_pkg::B_RST);
            c_reg     <= 17'(mwd_pkg::C_RST);
        end
        else
        begin
            if (cfg_wr && paddr[2] == mwd_pkg::REG_MODE)
                mode_reg <= pwdata[1:0];
            if (cfg_wr && paddr[2] == mwd_pkg::REG_DRIVE)
                drive_reg <= pwdata[15:0];
            g_reg <= g_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign jfet = (mode_reg == mwd_pkg::MODE_JFET);
    assign fuzz = (mode_reg == mwd_pkg::MODE_FUZZ);

    // ---------------- pipeline control ----------------
    assign en       = m_tready | ~valid_reg[10];
    assign s_tready = en;
    assign m_tvalid = valid_reg[10];
    assign m_tlast  = last_reg[10];
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[9:0], s_tvalid};
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        // stage 1: x = g * s
        s_in    = $signed({sample_pipe_reg[0], 3'b000});
        gs_prod = $signed({1'b0, g_reg}) * s_in;
        x_next  = 32'((gs_prod + 49'sd32768) >>> 16);

        // stage 2: x squared, tanh argument for jfet and fuzz
        xsq           = x_pipe_reg[1] * x_pipe_reg[1];
        xx_next       = xsq[61:0];
        x35           = 35'(x_pipe_reg[1]);
        flag_next.pos = x_pipe_reg[1] > 32'sd0;
        flag_next.fhi = x_pipe_reg[1] > mwd_pkg::FUZZ_POS;
        flag_next.flo = x_pipe_reg[1] < -mwd_pkg::FUZZ_NEG;
        ex_sel = flag_next.fhi ? (x35 - 35'(mwd_pkg::FUZZ_POS))
                               : (-x35 - 35'(mwd_pkg::FUZZ_NEG));
        if (jfet)
            arg_next = flag_next.pos ? ((x35 + (x35 <<< 1)) >>> 1) : (x35 <<< 1);
        else
            arg_next = (ex_sel <<< 2) + ex_sel;

        // stage 3: 0.15 x^2
        sq       = 38'((xx_reg + 62'd8388608) >> 24);
        sqm_next = 52'(sq) * 52'(mwd_pkg::TUBE_K);

        // stage 4: tanh argument
        sqm_rnd = 36'((sqm_reg + 52'd32768) >> 16);
        if (!jfet && !fuzz)
            u_next = 38'(x_pipe_reg[3]) + $signed({2'b00, sqm_rnd});
        else
            u_next = 38'(arg3_reg);

        // stage 5: table read
        neg5_next  = u_reg[37];
        umag       = neg5_next ? 38'(-u_reg) : 38'(u_reg);
        sat5_next  = |umag[37:mwd_pkg::FRAC_W];
        idx        = {1'b0, umag[mwd_pkg::FRAC_W-1 -: mwd_pkg::TANH_LOG2]};
        idx_nx     = idx + 9'd1;
        base5_next = mwd_pkg::TANH_ROM[idx];
        diff5_next = 25'(mwd_pkg::TANH_ROM[idx_nx] - mwd_pkg::TANH_ROM[idx]);
        frac5_next = {umag[mwd_pkg::FRAC_W-1-mwd_pkg::TANH_LOG2:0],
                      {mwd_pkg::TANH_LOG2{1'b0}}};

        // stage 6: interpolation product
        prod_next = 51'(diff5_reg) * 51'(frac5_reg);

        // stage 7: |tanh| in Q.24
        tsum      = 32'(base6_reg) + 32'(prod_reg >> mwd_pkg::FRAC_W);
        thm7_next = sat6_reg ? 25'(1 << mwd_pkg::IFRAC)
                             : 25'((tsum + 32'd32) >> (mwd_pkg::TQ - mwd_pkg::IFRAC));

        // stage 8: 0.8 or 0.1 scaling of |tanh|
        mconst = fuzz ? mwd_pkg::KNEE_K : 21'(mwd_pkg::NEG_K);
        m_next = 46'(thm7_reg) * 46'(mconst);

        // stage 9: mixing products and the simple paths
        knee    = 22'((m_reg + 46'd8388608) >> 24);
        dmag    = 26'((m_reg + 46'd32768) >> 16);
        d_val   = flag_pipe_reg[8].pos ? $signed(26'(thm8_reg)) : -$signed(dmag);
        th_val  = neg8_reg ? -$signed(26'(thm8_reg)) : $signed(26'(thm8_reg));
        s_mix   = $signed({sample_pipe_reg[8], 3'b000});
        cs_next = $signed({1'b0, c_reg}) * s_mix;
        bd_next = $signed({1'b0, b_reg}) * d_val;
        if (fuzz)
        begin
            if (flag_pipe_reg[8].fhi)
                ys_next = mwd_pkg::FUZZ_POS + $signed({10'd0, knee});
            else if (flag_pipe_reg[8].flo)
                ys_next = -mwd_pkg::FUZZ_NEG - $signed({10'd0, knee});
            else
                ys_next = x_pipe_reg[8];
        end
        else
            ys_next = 32'(th_val);

        // stage 10: final rounding to Q2.21 and clamp
        jsum  = 46'(cs_reg) + 46'(bd_reg) + 46'sd32768;
        y_val = jfet ? 32'(jsum >>> 16) : ys_reg;
        y_rnd = (33'(y_val) + 33'sd4) >>> 3;
        if (y_rnd > 33'sd8388607)
            out_next = 24'h7FFFFF;
        else if (y_rnd < -33'sd8388608)
            out_next = 24'h800000;
        else
            out_next = y_rnd[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_pipe_reg[0] <= s_tdata;
            for (int k = 1; k <= 8; k++)
                sample_pipe_reg[k] <= sample_pipe_reg[k-1];
            last_reg <= {last_reg[9:0], s_tlast};

            x_pipe_reg[1] <= x_next;
            for (int k = 2; k <= 8; k++)
                x_pipe_reg[k] <= x_pipe_reg[k-1];
            flag_pipe_reg[2] <= flag_next;
            for (int k = 3; k <= 8; k++)
                flag_pipe_reg[k] <= flag_pipe_reg[k-1];

            xx_reg    <= xx_next;
            arg2_reg  <= arg_next;
            arg3_reg  <= arg2_reg;
            sqm_reg   <= sqm_next;
            u_reg     <= u_next;
            neg5_reg  <= neg5_next;
            sat5_reg  <= sat5_next;
            base5_reg <= base5_next;
            diff5_reg <= diff5_next;
            frac5_reg <= frac5_next;
            prod_reg  <= prod_next;
            base6_reg <= base5_reg;
            neg6_reg  <= neg5_reg;
            sat6_reg  <= sat5_reg;
            thm7_reg  <= thm7_next;
            neg7_reg  <= neg6_reg;
            m_reg     <= m_next;
            thm8_reg  <= thm7_reg;
            neg8_reg  <= neg7_reg;
            cs_reg    <= cs_next;
            bd_reg    <= bd_next;
            ys_reg    <= ys_next;
            out_reg   <= out_next;
        end
    end

endmodule

[sv/mwd_checker.sv]
// Port-level checks for the multimode waveshaper, bound to its top level.
// Depends on mwd_pkg for register indexes.
module mwd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;

    // held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // a stalled output freezes the pipeline, so no new item may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item accepted while the pipeline is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[2] == mwd_pkg::REG_DRIVE ##1 !pwrite && paddr[2] == mwd_pkg::REG_DRIVE
        |-> prdata == {16'd0, $past(pwdata[15:0])})
        else $error("drive readback mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[2] == mwd_pkg::REG_MODE ##1 !pwrite && paddr[2] == mwd_pkg::REG_MODE
        |-> prdata == {30'd0, $past(pwdata[1:0])})
        else $error("mode readback mismatch");

endmodule

bind multimode_waveshaper_distortion mwd_checker u_mwd_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for multimode_waveshaper_distortion: tube, JFET and fuzz curves,
// register writes over APB, and stream handshakes with random idling and a long hold-off.
// Depends on mwd_pkg and the block; the shaping is predicted by a local fixed-point model.
module testbench;

    localparam int     PIPE_LAT    = 11;
    localparam int     SETTLE_CYC  = 6;
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     LUT_PTS     = 256;
    localparam int     LUT_Q       = 30;
    localparam int     IQ          = 24;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint FUZZ_HI     = 64'sd11744051;
    localparam longint FUZZ_LO     = 64'sd10066330;
    localparam longint KNEE_GAIN   = 64'sd1677722;
    localparam longint SQ_GAIN     = 64'sd9830;
    localparam longint CLEAN_GAIN  = 64'sd39322;
    localparam longint NEG_GAIN    = 64'sd52429;
    localparam logic [23:0] S_MAX  = 24'h7FFFFF;
    localparam logic [23:0] S_MIN  = 24'h800000;

    typedef struct {
        logic [23:0] sample;
        logic        last;
    } shaped_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [23:0] sample_in
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [23:0] sample_out
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [1:0]  cfg_mode;
    logic [15:0] cfg_drive;
    longint      tanh_lut [0:LUT_PTS];
    shaped_t     shaped_q [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        out_hold = 1'b0;

    multimode_waveshaper_distortion i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tanh(4k/N) in Q.30, built by the addition formula from a series step
    initial
    begin : lut_fill
        longint unsigned d, d2, d3, d5, d7, h, t, den;
        d  = ((64'd4 << LUT_Q) + LUT_PTS / 2) / LUT_PTS;
        d2 = (d * d) >> LUT_Q;
        d3 = (d2 * d) >> LUT_Q;
        d5 = (d3 * d2) >> LUT_Q;
        d7 = (d5 * d2) >> LUT_Q;
        h  = d - d3 / 3 + (2 * d5) / 15 - (17 * d7) / 315;
        t  = 0;
        tanh_lut[0] = 0;
        for (int k = 1; k <= LUT_PTS; k++)
        begin
            den = (64'd1 << LUT_Q) + ((t * h) >> LUT_Q);
            t   = (((t + h) << LUT_Q) + den / 2) / den;
            tanh_lut[k] = longint'(t);
        end
    end

    function automatic longint round_shr(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Q.24 in, Q.24 out; exact +-1 from |u| = 4 up
    function automatic longint tanh_fix(input longint u);
        longint mag, p, idx, f, t, r;
        mag = (u < 0) ? -u : u;
        if (mag >= (longint'(4) <<< IQ))
            r = longint'(1) <<< IQ;
        else
        begin
            p   = mag * LUT_PTS;
            idx = p >>> (IQ + 2);
            f   = p & ((longint'(1) <<< (IQ + 2)) - 1);
            if (idx >= LUT_PTS)
                idx = LUT_PTS - 1;
            t = tanh_lut[idx] + (((tanh_lut[idx + 1] - tanh_lut[idx]) * f) >>> (IQ + 2));
            r = (t + 32) >>> (LUT_Q - IQ);
        end
        return (u < 0) ? -r : r;
    endfunction

    function automatic shaped_t shape_sample(input logic [23:0] smp, input logic lst);
        longint  s, g, x, y, b, c, d, t, sq;
        shaped_t res;
        s = longint'($signed(smp)) <<< 3;
        g = 65536 + 19 * longint'(cfg_drive);
        x = round_shr(g * s, 16);
        case (cfg_mode)
            mwd_pkg::MODE_JFET:
            begin
                b = g / 5;
                if (b > 65536)
                    b = 65536;
                c = 65536 - round_shr(b * CLEAN_GAIN, 16);
                if (x > 0)
                    d = tanh_fix((3 * x) >>> 1);
                else
                begin
                    t = tanh_fix(2 * x);
                    d = -round_shr(-t * NEG_GAIN, 16);
                end
                y = round_shr(c * s + b * d, 16);
            end
            mwd_pkg::MODE_FUZZ:
            begin
                if (x > FUZZ_HI)
                    y = FUZZ_HI + round_shr(tanh_fix(5 * (x - FUZZ_HI)) * KNEE_GAIN, IQ);
                else if (x < -FUZZ_LO)
                    y = -FUZZ_LO - round_shr(tanh_fix(5 * (-x - FUZZ_LO)) * KNEE_GAIN, IQ);
                else
                    y = x;
            end
            default:
            begin
                sq = round_shr(x * x, IQ);
                y  = tanh_fix(x + round_shr(sq * SQ_GAIN, 16));
            end
        endcase
        y = round_shr(y, 3);
        if (y > longint'($signed(S_MAX)))
            y = longint'($signed(S_MAX));
        if (y < longint'($signed(S_MIN)))
            y = longint'($signed(S_MIN));
        res.sample = y[23:0];
        res.last   = lst;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_cnt++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        shaped_t want;
        if (rst_n && s_tvalid && s_tready)
            shaped_q.push_back(shape_sample(s_tdata, s_tlast));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (shaped_q.size() == 0)
                report_mismatch("item with none pending", m_tdata, 0);
            else
            begin
                want = shaped_q.pop_front();
                if (m_tdata !== want.sample)
                    report_mismatch("sample_out", m_tdata, want.sample);
                if (m_tlast !== want.last)
                    report_mismatch("last_out", m_tlast, want.last);
            end
        end
    end

    always @(negedge clk)
        m_tready <= out_hold ? 1'b0 : ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic hold_output(input int cycles);
        out_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        out_hold = 1'b0;
    endtask

    task automatic send_sample(input logic [23:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = lst;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_idle();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == mwd_pkg::REG_MODE)
            cfg_mode = val[1:0];
        else
            cfg_drive = val[15:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // mix of full-scale, near-zero and around-unity samples
    function automatic logic [23:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r[23:0];
            1: return {{8{r[16]}}, r[15:0]};
            2: return {{3{r[21]}}, r[20:0]};
            default: return {{2{r[22]}}, r[21:0]};
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(24'h000000, 1'b0);
        send_sample(S_MAX, 1'b1);
    endtask

    task automatic test_tube_curve();
        write_reg(mwd_pkg::REG_MODE, {30'd0, mwd_pkg::MODE_TUBE});
        write_reg(mwd_pkg::REG_DRIVE, 32'd0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'h000001, 1'b0);
    endtask

    task automatic test_jfet_blend();
        write_reg(mwd_pkg::REG_MODE, {30'd0, mwd_pkg::MODE_JFET});
        write_reg(mwd_pkg::REG_DRIVE, 32'h0000FFFF);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h100000, 1'b1);
        send_sample(24'hFFFFFF, 1'b0);
    endtask

    // samples either side of the +0.7 and -0.6 clip points at unity gain
    task automatic test_fuzz_clip();
        write_reg(mwd_pkg::REG_MODE, {30'd0, mwd_pkg::MODE_FUZZ});
        write_reg(mwd_pkg::REG_DRIVE, 32'd0);
        send_sample(24'd1468006, 1'b0);
        send_sample(24'd1468007, 1'b0);
        send_sample(-24'sd1258291, 1'b0);
        send_sample(-24'sd1258292, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
    endtask

    // spare mode code acts as tube; upper data bits are dropped
    task automatic test_register_width();
        write_reg(mwd_pkg::REG_MODE, {30'h3FFFFFFF, MODE_SPARE});
        write_reg(mwd_pkg::REG_DRIVE, 32'hFFFF1234);
        send_sample(S_MAX, 1'b1);
        send_sample(24'h2A0000, 1'b0);
        send_sample(24'hD60000, 1'b0);
    endtask

    task automatic test_output_holdoff();
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            hold_output(300);
        join_none
        repeat (60) send_sample(pick_sample(), ($urandom_range(7) == 0));
        wait_idle();
        repeat (20) send_sample(pick_sample(), ($urandom_range(7) == 0));
    endtask

    task automatic test_random_stream();
        int          idle_set [4]  = '{0, 71, 0, 37};
        int          stall_set [4] = '{0, 0, 71, 37};
        logic [31:0] word;
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                word      = $urandom;
                word[1:0] = 2'((ph * 3 + k) % 4);
                write_reg(mwd_pkg::REG_MODE, word);
                word = $urandom;
                if (k == 0)
                    word[15:0] = 16'h0000;
                else if (k == 1)
                    word[15:0] = 16'hFFFF;
                write_reg(mwd_pkg::REG_DRIVE, word);
                send_idle_pct = idle_set[ph];
                stall_pct     = stall_set[ph];
                repeat (150) send_sample(pick_sample(), ($urandom_range(7) == 0));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cfg_mode  = mwd_pkg::MODE_RST;
        cfg_drive = mwd_pkg::DRIVE_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_tube_curve();
        test_jfet_blend();
        test_fuzz_clip();
        test_register_width();
        test_output_holdoff();
        test_random_stream();
        wait_idle();
        repeat (PIPE_LAT * 2) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
